// File: hw/rtl/damage_region_compositor_top_defines.svh
// Assertion macros shared by the compositor modules
`ifndef DAMAGE_REGION_COMPOSITOR_TOP_DEFINES_SVH
`define DAMAGE_REGION_COMPOSITOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define DRC_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define DRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/drc_pkg.sv
// Package: types, codes and constants of the damage region compositor
package drc_pkg;

  localparam int SCREEN_MAX = 4096;
  localparam int SCR_W      = 13;
  localparam int DMG_W      = 18;
  localparam int ARITH_W    = 19;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
  localparam logic [15:0] BG_TAG       = 16'h0000;

  typedef logic signed [ARITH_W-1:0] coord_t;

  typedef enum logic [2:0] {
    CMD_ADD_DAMAGE    = 3'd0,
    CMD_DAMAGE_SCREEN = 3'd1,
    CMD_BEGIN_FRAME   = 3'd2,
    CMD_WINDOW        = 3'd3,
    CMD_END_FRAME     = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    OP_FILL      = 2'd0,
    OP_BG_BLIT   = 2'd1,
    OP_WIN_BLIT  = 2'd2,
    OP_WIN_BLEND = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BG_IMAGE      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_BG_FILL       = CFG_IDX_W'(3);

  typedef struct packed {
    logic [SCR_W-1:0] screen_width;
    logic [SCR_W-1:0] screen_height;
    logic             background_image_present;
    logic [31:0]      background_fill;
  } cfg_t;

  typedef struct packed {
    op_t         opcode;
    logic [15:0] source_tag;
    logic [11:0] dst_x;
    logic [11:0] dst_y;
    logic [12:0] width;
    logic [12:0] height;
    logic [15:0] src_x;
    logic [15:0] src_y;
    logic [7:0]  blend_alpha;
    logic [31:0] fill_color;
  } result_t;

  function automatic logic [SCR_W-1:0] clamp_screen(input logic [SCR_W-1:0] v);
    logic [SCR_W-1:0] r;
    if (v == '0) begin
      r = SCR_W'(1);
    end else if (v > SCR_W'(SCREEN_MAX)) begin
      r = SCR_W'(SCREEN_MAX);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/drc_if.sv
// Channel interfaces: configuration writes, input items and drawing command words
interface drc_cfg_if import drc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface drc_item_if import drc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [2:0]         cmd;
  logic signed [15:0] x;
  logic signed [15:0] y;
  logic signed [15:0] w;
  logic signed [15:0] h;
  logic [7:0]         win_alpha;
  logic               transparent;
  logic               visible;
  logic               has_surface;
  logic [15:0]        surface_tag;

  modport source (output valid, cmd, x, y, w, h, win_alpha, transparent, visible,
                  has_surface, surface_tag, input ready);
  modport sink (input valid, cmd, x, y, w, h, win_alpha, transparent, visible,
                has_surface, surface_tag, output ready);
endinterface

interface drc_cmd_if import drc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] source_tag;
  logic [11:0] dst_x;
  logic [11:0] dst_y;
  logic [12:0] width;
  logic [12:0] height;
  logic [15:0] src_x;
  logic [15:0] src_y;
  logic [7:0]  blend_alpha;
  logic [31:0] fill_color;

  modport source (output valid, opcode, source_tag, dst_x, dst_y, width, height,
                  src_x, src_y, blend_alpha, fill_color, input ready);
  modport sink (input valid, opcode, source_tag, dst_x, dst_y, width, height,
                src_x, src_y, blend_alpha, fill_color, output ready);
endinterface

// File: hw/rtl/drc_cfg.sv
// Configuration register bank
module drc_cfg import drc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  drc_cfg_if.sink    cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.screen_width             <= SCR_W'(640);
      regs.screen_height            <= SCR_W'(480);
      regs.background_image_present <= 1'b0;
      regs.background_fill          <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_SCREEN_WIDTH:  regs.screen_width             <= cfg.data[SCR_W-1:0];
        CFG_SCREEN_HEIGHT: regs.screen_height            <= cfg.data[SCR_W-1:0];
        CFG_BG_IMAGE:      regs.background_image_present <= cfg.data[0];
        CFG_BG_FILL:       regs.background_fill          <= cfg.data[31:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/drc_core.sv
// Damage box state and per-word command generation
`include "damage_region_compositor_top_defines.svh"

module drc_core import drc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  drc_item_if.sink   items,
  input  cfg_t       regs,
  input  logic       space,
  output logic       res_valid,
  output result_t    res
);

  logic signed [DMG_W-1:0] damage_left, damage_top, damage_width, damage_height;
  logic signed [DMG_W-1:0] damage_left_next, damage_top_next;
  logic signed [DMG_W-1:0] damage_width_next, damage_height_next;
  logic                    frame_active, frame_active_next;
  logic [31:0]             frame_counter, frame_counter_next;

  logic   fire;
  coord_t xs, ys, ws, hs, sw, sh, dl, dt, dw, dh;
  coord_t src_l, src_t, src_w, src_h;
  coord_t m_l, m_t, m_r, m_b;
  coord_t c_l, c_t, c_w0, c_h0, c_w, c_h;
  coord_t i_l, i_t, i_r, i_b, i_w, i_h;
  logic   dmg_empty, src_empty, clip_empty, opaque;

  assign items.ready = space;
  assign fire        = items.valid && space;

  always_comb begin
    xs = ARITH_W'(items.x);
    ys = ARITH_W'(items.y);
    ws = ARITH_W'(items.w);
    hs = ARITH_W'(items.h);
    sw = ARITH_W'(clamp_screen(regs.screen_width));
    sh = ARITH_W'(clamp_screen(regs.screen_height));
    dl = ARITH_W'(damage_left);
    dt = ARITH_W'(damage_top);
    dw = ARITH_W'(damage_width);
    dh = ARITH_W'(damage_height);
    dmg_empty = (dw <= 0) || (dh <= 0);

    if (items.cmd == CMD_DAMAGE_SCREEN) begin
      src_l = '0;
      src_t = '0;
      src_w = sw;
      src_h = sh;
    end else begin
      src_l = xs;
      src_t = ys;
      src_w = ws;
      src_h = hs;
    end
    src_empty = (src_w <= 0) || (src_h <= 0);
    m_l = (dl < src_l) ? dl : src_l;
    m_t = (dt < src_t) ? dt : src_t;
    m_r = (src_l + src_w > dl + dw) ? src_l + src_w : dl + dw;
    m_b = (src_t + src_h > dt + dh) ? src_t + src_h : dt + dh;

    c_l  = (dl < 0) ? '0 : dl;
    c_t  = (dt < 0) ? '0 : dt;
    c_w0 = (dl < 0) ? dw + dl : dw;
    c_h0 = (dt < 0) ? dh + dt : dh;
    c_w  = (c_l + c_w0 > sw) ? sw - c_l : c_w0;
    c_h  = (c_t + c_h0 > sh) ? sh - c_t : c_h0;
    clip_empty = (c_w <= 0) || (c_h <= 0);

    i_l = (dl > xs) ? dl : xs;
    i_t = (dt > ys) ? dt : ys;
    i_r = (xs + ws < dl + dw) ? xs + ws : dl + dw;
    i_b = (ys + hs < dt + dh) ? ys + hs : dt + dh;
    i_w = i_r - i_l;
    i_h = i_b - i_t;
    opaque = (items.win_alpha == ALPHA_OPAQUE) && !items.transparent;
  end

  always_comb begin
    damage_left_next   = damage_left;
    damage_top_next    = damage_top;
    damage_width_next  = damage_width;
    damage_height_next = damage_height;
    frame_active_next  = frame_active;
    frame_counter_next = frame_counter;
    res_valid          = 1'b0;
    res                = '0;
    if (fire) begin
      case (items.cmd)
        CMD_ADD_DAMAGE, CMD_DAMAGE_SCREEN: begin
          if (!frame_active && !src_empty) begin
            if (dmg_empty) begin
              damage_left_next   = DMG_W'(src_l);
              damage_top_next    = DMG_W'(src_t);
              damage_width_next  = DMG_W'(src_w);
              damage_height_next = DMG_W'(src_h);
            end else begin
              damage_left_next   = DMG_W'(m_l);
              damage_top_next    = DMG_W'(m_t);
              damage_width_next  = DMG_W'(m_r - m_l);
              damage_height_next = DMG_W'(m_b - m_t);
            end
          end
        end
        CMD_BEGIN_FRAME: begin
          frame_active_next = 1'b0;
          if (!dmg_empty) begin
            if (clip_empty) begin
              damage_left_next   = '0;
              damage_top_next    = '0;
              damage_width_next  = '0;
              damage_height_next = '0;
            end else begin
              damage_left_next   = DMG_W'(c_l);
              damage_top_next    = DMG_W'(c_t);
              damage_width_next  = DMG_W'(c_w);
              damage_height_next = DMG_W'(c_h);
              frame_active_next  = 1'b1;
              res_valid          = 1'b1;
              res.source_tag     = BG_TAG;
              res.dst_x          = c_l[11:0];
              res.dst_y          = c_t[11:0];
              res.width          = c_w[12:0];
              res.height         = c_h[12:0];
              if (regs.background_image_present) begin
                res.opcode = OP_BG_BLIT;
                res.src_x  = c_l[15:0];
                res.src_y  = c_t[15:0];
              end else begin
                res.opcode     = OP_FILL;
                res.fill_color = regs.background_fill;
              end
            end
          end
        end
        CMD_WINDOW: begin
          if (frame_active && items.visible && items.has_surface &&
              (i_w > 0) && (i_h > 0)) begin
            res_valid       = 1'b1;
            res.opcode      = opaque ? OP_WIN_BLIT : OP_WIN_BLEND;
            res.source_tag  = items.surface_tag;
            res.dst_x       = i_l[11:0];
            res.dst_y       = i_t[11:0];
            res.width       = i_w[12:0];
            res.height      = i_h[12:0];
            res.src_x       = 16'(i_l - xs);
            res.src_y       = 16'(i_t - ys);
            res.blend_alpha = opaque ? 8'd0 : items.win_alpha;
          end
        end
        CMD_END_FRAME: begin
          if (frame_active) begin
            frame_counter_next = frame_counter + 32'd1;
            damage_left_next   = '0;
            damage_top_next    = '0;
            damage_width_next  = '0;
            damage_height_next = '0;
            frame_active_next  = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      damage_left   <= '0;
      damage_top    <= '0;
      damage_width  <= '0;
      damage_height <= '0;
      frame_active  <= 1'b0;
      frame_counter <= '0;
    end else begin
      damage_left   <= damage_left_next;
      damage_top    <= damage_top_next;
      damage_width  <= damage_width_next;
      damage_height <= damage_height_next;
      frame_active  <= frame_active_next;
      frame_counter <= frame_counter_next;
    end
  end

  `DRC_ASSERT_HOLDS(a_frame_box_on_screen, frame_active, !damage_left[DMG_W-1] && !damage_top[DMG_W-1] && (damage_width > 0) && (damage_height > 0), "active frame damage box not clipped")
  `DRC_ASSERT_HOLDS(a_result_in_frame, res_valid, fire && (frame_active || items.cmd == CMD_BEGIN_FRAME), "command word outside a frame")
  `DRC_ASSERT_NEXT(a_frame_count, fire && frame_active && items.cmd == CMD_END_FRAME, frame_counter == $past(frame_counter) + 32'd1, "frame count did not advance")

endmodule

// File: hw/rtl/drc_out_buf.sv
// Output register with skid stage for command words
`include "damage_region_compositor_top_defines.svh"

module drc_out_buf import drc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  result_t    push_data,
  output logic       space,
  drc_cmd_if.source  cmds
);

  logic    out_valid, skid_valid, pop;
  result_t out_data, skid_data;

  assign space = !skid_valid;
  assign pop   = out_valid && cmds.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

  assign cmds.valid       = out_valid;
  assign cmds.opcode      = out_data.opcode;
  assign cmds.source_tag  = out_data.source_tag;
  assign cmds.dst_x       = out_data.dst_x;
  assign cmds.dst_y       = out_data.dst_y;
  assign cmds.width       = out_data.width;
  assign cmds.height      = out_data.height;
  assign cmds.src_x       = out_data.src_x;
  assign cmds.src_y       = out_data.src_y;
  assign cmds.blend_alpha = out_data.blend_alpha;
  assign cmds.fill_color  = out_data.fill_color;

  `DRC_ASSERT_HOLDS(a_skid_behind_out, skid_valid, out_valid, "skid stage full with output empty")

endmodule

// File: hw/rtl/damage_region_compositor_top.sv
// Damage region compositor top level
// A command word is registered in the output register, or in the skid stage while the output holds a waiting word.
// Throughput: one item per cycle while the skid stage is empty; the damage box update is a single registered step.
// A skid stage holds a second word: input stalls only once two words wait at the output.
// Reset (synchronous): damage box cleared, no frame active, frame count zero,
// configuration back to 640 by 480 with background fill of colour zero.
module damage_region_compositor_top import drc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  drc_cfg_if.sink    cfg,
  drc_item_if.sink   items,
  drc_cmd_if.source  cmds
);

  cfg_t    regs;
  logic    space;
  logic    res_valid;
  result_t res;

  drc_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  drc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .regs      (regs),
    .space     (space),
    .res_valid (res_valid),
    .res       (res)
  );

  drc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .cmds      (cmds)
  );

endmodule

// File: test/damage_region_compositor_top_tb.sv
// Self-checking testbench for the damage region compositor: directed and random frames against a predictor
module damage_region_compositor_top_tb import drc_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] CMD_UNKNOWN_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = CFG_IDX_W'(8'hFC);

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic [7:0]         win_alpha;
    logic               transparent;
    logic               visible;
    logic               has_surface;
    logic [15:0]        surface_tag;
  } item_t;

  class frame_ledger;
    cfg_t        regs;
    int          dmg_l, dmg_t, dmg_w, dmg_h;
    bit          in_frame;
    int unsigned frames_done;
    result_t     due[$];
    int          fails;
    int          op_seen[4];

    function new();
      regs.screen_width = SCR_W'(640);
      regs.screen_height = SCR_W'(480);
      regs.background_image_present = 1'b0;
      regs.background_fill = 32'h0;
      clear_box();
      in_frame = 1'b0;
      frames_done = 0;
      fails = 0;
    endfunction

    function void clear_box();
      dmg_l = 0;
      dmg_t = 0;
      dmg_w = 0;
      dmg_h = 0;
    endfunction

    function int screen_span(bit vert);
      logic [SCR_W-1:0] v;
      v = vert ? regs.screen_height : regs.screen_width;
      if (v == '0) return 1;
      if (v > SCREEN_MAX) return SCREEN_MAX;
      return int'(v);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_SCREEN_WIDTH: regs.screen_width = val[SCR_W-1:0];
        CFG_SCREEN_HEIGHT: regs.screen_height = val[SCR_W-1:0];
        CFG_BG_IMAGE: regs.background_image_present = val[0];
        CFG_BG_FILL: regs.background_fill = val;
        default: ;
      endcase
    endfunction

    function void grow(int x, int y, int w, int h);
      int l, t, r, b;
      if (w <= 0 || h <= 0) return;
      if (dmg_w <= 0 || dmg_h <= 0) begin
        dmg_l = x;
        dmg_t = y;
        dmg_w = w;
        dmg_h = h;
        return;
      end
      l = (dmg_l < x) ? dmg_l : x;
      t = (dmg_t < y) ? dmg_t : y;
      r = dmg_l + dmg_w;
      if (x + w > r) r = x + w;
      b = dmg_t + dmg_h;
      if (y + h > b) b = y + h;
      dmg_l = l;
      dmg_t = t;
      dmg_w = r - l;
      dmg_h = b - t;
    endfunction

    function void take_item(item_t it);
      int sw, sh, x, y, w, h, ix, iy, rx, by;
      result_t r;
      sw = screen_span(1'b0);
      sh = screen_span(1'b1);
      x = $signed(it.x);
      y = $signed(it.y);
      w = $signed(it.w);
      h = $signed(it.h);
      r = '0;
      case (it.cmd)
        CMD_ADD_DAMAGE: if (!in_frame) grow(x, y, w, h);
        CMD_DAMAGE_SCREEN: if (!in_frame) grow(0, 0, sw, sh);
        CMD_BEGIN_FRAME: begin
          in_frame = 1'b0;
          if (dmg_w > 0 && dmg_h > 0) begin
            if (dmg_l < 0) begin
              dmg_w += dmg_l;
              dmg_l = 0;
            end
            if (dmg_t < 0) begin
              dmg_h += dmg_t;
              dmg_t = 0;
            end
            if (dmg_l + dmg_w > sw) dmg_w = sw - dmg_l;
            if (dmg_t + dmg_h > sh) dmg_h = sh - dmg_t;
            if (dmg_w <= 0 || dmg_h <= 0) begin
              clear_box();
            end else begin
              in_frame = 1'b1;
              r.source_tag = BG_TAG;
              r.dst_x = 12'(dmg_l);
              r.dst_y = 12'(dmg_t);
              r.width = 13'(dmg_w);
              r.height = 13'(dmg_h);
              if (regs.background_image_present) begin
                r.opcode = OP_BG_BLIT;
                r.src_x = 16'(dmg_l);
                r.src_y = 16'(dmg_t);
              end else begin
                r.opcode = OP_FILL;
                r.fill_color = regs.background_fill;
              end
              due.push_back(r);
            end
          end
        end
        CMD_WINDOW: begin
          if (in_frame && it.visible && it.has_surface) begin
            ix = (dmg_l > x) ? dmg_l : x;
            iy = (dmg_t > y) ? dmg_t : y;
            rx = dmg_l + dmg_w;
            if (x + w < rx) rx = x + w;
            by = dmg_t + dmg_h;
            if (y + h < by) by = y + h;
            if (rx > ix && by > iy) begin
              if (it.win_alpha == ALPHA_OPAQUE && !it.transparent) begin
                r.opcode = OP_WIN_BLIT;
              end else begin
                r.opcode = OP_WIN_BLEND;
                r.blend_alpha = it.win_alpha;
              end
              r.source_tag = it.surface_tag;
              r.dst_x = 12'(ix);
              r.dst_y = 12'(iy);
              r.width = 13'(rx - ix);
              r.height = 13'(by - iy);
              r.src_x = 16'(ix - x);
              r.src_y = 16'(iy - y);
              due.push_back(r);
            end
          end
        end
        CMD_END_FRAME: begin
          if (in_frame) begin
            frames_done++;
            clear_box();
            in_frame = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        fails++;
      end
    endfunction

    function void match_word(result_t got);
      result_t want;
      if (due.size() == 0) begin
        $error("drawing word with nothing expected: opcode 0x%0h tag 0x%0h",
               got.opcode, got.source_tag);
        fails++;
        return;
      end
      want = due.pop_front();
      op_seen[int'(want.opcode)]++;
      cmp_field("opcode", want.opcode, got.opcode);
      cmp_field("source_tag", want.source_tag, got.source_tag);
      cmp_field("dst_x", want.dst_x, got.dst_x);
      cmp_field("dst_y", want.dst_y, got.dst_y);
      cmp_field("width", want.width, got.width);
      cmp_field("height", want.height, got.height);
      cmp_field("src_x", want.src_x, got.src_x);
      cmp_field("src_y", want.src_y, got.src_y);
      cmp_field("blend_alpha", want.blend_alpha, got.blend_alpha);
      cmp_field("fill_color", want.fill_color, got.fill_color);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  int   idle_pct;
  int   stall_pct;
  int   hold_req;
  int   hold_left;
  int   sent;
  int   cycle_count;
  frame_ledger ledger;

  drc_cfg_if  cfg_ch ();
  drc_item_if item_ch ();
  drc_cmd_if  cmd_ch ();

  damage_region_compositor_top DUT (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_ch),
    .items (item_ch),
    .cmds  (cmd_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // hold off the command word stream on request, else stall at random
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      cmd_ch.ready = 1'b0;
      hold_left--;
    end else begin
      cmd_ch.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : watch_words
    result_t word;
    if (!rst && cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) begin
      word.opcode = op_t'(cmd_ch.opcode);
      word.source_tag = cmd_ch.source_tag;
      word.dst_x = cmd_ch.dst_x;
      word.dst_y = cmd_ch.dst_y;
      word.width = cmd_ch.width;
      word.height = cmd_ch.height;
      word.src_x = cmd_ch.src_x;
      word.src_y = cmd_ch.src_y;
      word.blend_alpha = cmd_ch.blend_alpha;
      word.fill_color = cmd_ch.fill_color;
      ledger.match_word(word);
    end
  end

  function automatic item_t noise_item(logic [2:0] c);
    item_t it;
    it.cmd = c;
    it.x = 16'($urandom);
    it.y = 16'($urandom);
    it.w = 16'($urandom);
    it.h = 16'($urandom);
    it.win_alpha = 8'($urandom);
    it.transparent = 1'($urandom);
    it.visible = 1'($urandom);
    it.has_surface = 1'($urandom);
    it.surface_tag = 16'($urandom);
    return it;
  endfunction

  function automatic item_t rect_item(logic [2:0] c, int x, int y, int w, int h);
    item_t it;
    it = noise_item(c);
    it.x = 16'(x);
    it.y = 16'(y);
    it.w = 16'(w);
    it.h = 16'(h);
    return it;
  endfunction

  function automatic item_t window_item(int x, int y, int w, int h, logic [7:0] alpha,
                                        bit tr, bit vis, bit surf, logic [15:0] tag);
    item_t it;
    it = rect_item(CMD_WINDOW, x, y, w, h);
    it.win_alpha = alpha;
    it.transparent = tr;
    it.visible = vis;
    it.has_surface = surf;
    it.surface_tag = tag;
    return it;
  endfunction

  function automatic void pick_rect(output int x, output int y, output int w, output int h);
    int sw, sh, sel;
    sw = ledger.screen_span(1'b0);
    sh = ledger.screen_span(1'b1);
    sel = $urandom_range(19);
    if (sel == 0) begin
      x = $signed(16'($urandom));
      y = $signed(16'($urandom));
      w = $signed(16'($urandom));
      h = $signed(16'($urandom));
    end else if (sel == 1) begin
      x = $urandom_range(1) ? -32768 : 32767;
      y = $urandom_range(1) ? -32768 : 32767;
      w = $urandom_range(1) ? 32767 : -32768;
      h = $urandom_range(1) ? 32767 : 0;
    end else begin
      x = int'($urandom_range(sw + 32)) - 16;
      y = int'($urandom_range(sh + 32)) - 16;
      w = int'($urandom_range(sw / 2 + 16)) - 2;
      h = int'($urandom_range(sh / 2 + 16)) - 2;
    end
  endfunction

  task automatic push(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      item_ch.valid = 1'b0;
      @(negedge clk);
    end
    item_ch.valid = 1'b1;
    item_ch.cmd = it.cmd;
    item_ch.x = it.x;
    item_ch.y = it.y;
    item_ch.w = it.w;
    item_ch.h = it.h;
    item_ch.win_alpha = it.win_alpha;
    item_ch.transparent = it.transparent;
    item_ch.visible = it.visible;
    item_ch.has_surface = it.has_surface;
    item_ch.surface_tag = it.surface_tag;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    ledger.take_item(it);
    if (it.cmd <= CMD_END_FRAME) sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    ledger.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic configure(input int sw, input int sh, input bit img, input logic [31:0] fill);
    write_reg(CFG_SCREEN_WIDTH, 32'(SCR_W'(sw)));
    write_reg(CFG_SCREEN_HEIGHT, 32'(SCR_W'(sh)));
    write_reg(CFG_BG_IMAGE, 32'(img));
    write_reg(CFG_BG_FILL, fill);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic settle();
    item_ch.valid = 1'b0;
    while (ledger.due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_frames(input int quota);
    int goal, x, y, w, h, k;
    logic [7:0] alpha;
    goal = sent + quota;
    while (sent < goal) begin
      if ($urandom_range(99) < 85) begin
        repeat ($urandom_range(3, 1)) begin
          pick_rect(x, y, w, h);
          push(rect_item(CMD_ADD_DAMAGE, x, y, w, h));
        end
        if ($urandom_range(9) == 0) push(noise_item(CMD_DAMAGE_SCREEN));
        push(noise_item(CMD_BEGIN_FRAME));
        repeat ($urandom_range(8)) begin
          k = $urandom_range(19);
          if (k == 0) begin
            pick_rect(x, y, w, h);
            push(rect_item(CMD_ADD_DAMAGE, x, y, w, h));
          end else if (k == 1) begin
            push(noise_item(CMD_BEGIN_FRAME));
          end else begin
            pick_rect(x, y, w, h);
            k = $urandom_range(9);
            alpha = (k < 4) ? ALPHA_OPAQUE : (k == 4) ? 8'h00 : 8'($urandom);
            push(window_item(x, y, w, h, alpha, $urandom_range(4) == 0,
                             $urandom_range(9) != 0, $urandom_range(9) != 0,
                             16'($urandom)));
          end
        end
        if ($urandom_range(9) != 0) push(noise_item(CMD_END_FRAME));
      end else begin
        push(noise_item(3'($urandom_range(7))));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    sent = 0;
    cycle_count = 0;
    cmd_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    item_ch.valid = 1'b0;
    item_ch.cmd = '0;
    item_ch.x = '0;
    item_ch.y = '0;
    item_ch.w = '0;
    item_ch.h = '0;
    item_ch.win_alpha = '0;
    item_ch.transparent = 1'b0;
    item_ch.visible = 1'b0;
    item_ch.has_surface = 1'b0;
    item_ch.surface_tag = '0;
    ledger = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset configuration: 640 by 480, fill of colour zero
    for (int k = 0; k < 3; k++) push(noise_item(3'(CMD_UNKNOWN_FIRST + k)));
    push(rect_item(CMD_ADD_DAMAGE, 0, 0, 0, 10));
    push(rect_item(CMD_ADD_DAMAGE, 0, 0, 10, -32768));
    push(noise_item(CMD_END_FRAME));
    push(window_item(0, 0, 100, 100, ALPHA_OPAQUE, 0, 1, 1, 16'h1234));
    push(noise_item(CMD_BEGIN_FRAME));
    push(rect_item(CMD_ADD_DAMAGE, -32768, -32768, 32767, 32767));
    push(noise_item(CMD_BEGIN_FRAME));
    push(rect_item(CMD_ADD_DAMAGE, 10, 20, 100, 50));
    push(rect_item(CMD_ADD_DAMAGE, -5, 5, 30, 30));
    push(noise_item(CMD_BEGIN_FRAME));
    push(window_item(0, 0, 64, 64, ALPHA_OPAQUE, 0, 1, 1, 16'hFFFF));
    push(window_item(8, 8, 64, 64, ALPHA_OPAQUE, 1, 1, 1, 16'h0001));
    push(window_item(-100, -100, 32767, 32767, 8'h00, 0, 1, 1, 16'h8000));
    push(window_item(0, 0, 640, 480, 8'h80, 0, 0, 1, 16'h0002));
    push(window_item(0, 0, 640, 480, ALPHA_OPAQUE, 0, 1, 0, 16'h0003));
    push(window_item(500, 400, 10, 10, ALPHA_OPAQUE, 0, 1, 1, 16'h0004));
    push(window_item(32767, 32767, 32767, 32767, 8'h7F, 0, 1, 1, 16'h0005));
    push(window_item(-32768, -32768, 32767, 32767, 8'h7F, 0, 1, 1, 16'h0006));
    push(rect_item(CMD_ADD_DAMAGE, 0, 0, 640, 480));
    push(noise_item(CMD_DAMAGE_SCREEN));
    push(noise_item(CMD_BEGIN_FRAME));
    push(noise_item(CMD_END_FRAME));
    push(noise_item(CMD_DAMAGE_SCREEN));
    push(rect_item(CMD_ADD_DAMAGE, 600, 400, 100, 100));
    push(noise_item(CMD_BEGIN_FRAME));
    push(window_item(630, 470, 32767, 32767, 8'hFE, 0, 1, 1, 16'h5555));
    push(noise_item(CMD_END_FRAME));

    for (int p = 0; p < 5; p++) begin
      settle();
      case (p)
        0: begin
          configure(1, 1, 1'b0, 32'hFFFF_FFFF);
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          configure(SCREEN_MAX, SCREEN_MAX, 1'b1, 32'h5A5A_A5A5);
          idle_pct = 77;
          stall_pct = 0;
        end
        2: begin
          configure(0, 8191, 1'b0, $urandom);
          idle_pct = 0;
          stall_pct = 77;
        end
        3: begin
          write_reg(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
          configure($urandom_range(SCREEN_MAX, 1), $urandom_range(SCREEN_MAX, 1),
                    1'($urandom), $urandom);
          idle_pct = 29;
          stall_pct = 29;
        end
        default: begin
          configure(640, 480, 1'b0, 32'h00FF_00FF);
          idle_pct = 0;
          stall_pct = 0;
          // fill the pipeline behind a long output hold-off
          push(noise_item(CMD_END_FRAME));
          hold_req = 80;
          push(noise_item(CMD_DAMAGE_SCREEN));
          push(noise_item(CMD_BEGIN_FRAME));
          repeat (30) begin
            push(window_item(-int'($urandom_range(50)), -int'($urandom_range(50)),
                             32767, 32767, 8'($urandom), 1'($urandom), 1, 1,
                             16'($urandom)));
          end
          push(noise_item(CMD_END_FRAME));
        end
      endcase
      run_frames(p == 4 ? 250 : 280);
    end

    settle();
    repeat (4) @(negedge clk);
    $display("covered %0d items and %0d closed frames over six screen settings", sent,
             ledger.frames_done);
    $display("checked words: %0d fill, %0d background blit, %0d window blit, %0d blend",
             ledger.op_seen[0], ledger.op_seen[1], ledger.op_seen[2], ledger.op_seen[3]);
    if (ledger.fails == 0 && ledger.due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
